FILE: hw/rtl/tli_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tli_pkg: shared types, constants and breakpoint tables
// Item types, sequencer states, register indexes and the ROM tables of the
// table linear interpolator.
// ----------------------------------------------------------------------------
package tli_pkg;

  // Table geometry. The point count is clamped to the legal range 2..64.
  localparam int TABLE_POINTS = 36;
  localparam int SLOTS        = 64;
  localparam int IDX_W        = $clog2(SLOTS);
  localparam int POINT_COUNT  = (TABLE_POINTS < 2) ? 2 :
                                (TABLE_POINTS > SLOTS) ? SLOTS : TABLE_POINTS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINT_COUNT - 1);

  localparam int DATA_W = 16;
  localparam logic [DATA_W-1:0] ONE_Q15 = 16'd32768;

  // Divider geometry: 32-bit dividend, one quotient bit per cycle.
  localparam int DIVIDEND_W = 2 * DATA_W;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_BAR_ONE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_BAR_TWO = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] photon_energy;
    logic              bar_select;
  } tli_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] reflect_probability;
    logic              out_of_range;
  } tli_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_MUL,
    ST_DIV_START,
    ST_DIV,
    ST_SCALE,
    ST_ROUND
  } tli_state_t;

  // Breakpoint energies, Q4.12. Slots beyond the given points read as zero.
  function automatic logic [DATA_W-1:0] bp_energy(input logic [IDX_W-1:0] idx);
    logic [DATA_W-1:0] v;
    case (idx)
      6'd0:  v = 16'd7813;   6'd1:  v = 16'd7935;   6'd2:  v = 16'd8061;
      6'd3:  v = 16'd8191;   6'd4:  v = 16'd8325;   6'd5:  v = 16'd8464;
      6'd6:  v = 16'd8607;   6'd7:  v = 16'd8756;   6'd8:  v = 16'd8909;
      6'd9:  v = 16'd9069;   6'd10: v = 16'd9233;   6'd11: v = 16'd9404;
      6'd12: v = 16'd9582;   6'd13: v = 16'd9766;   6'd14: v = 16'd9958;
      6'd15: v = 16'd10157;  6'd16: v = 16'd10364;  6'd17: v = 16'd10580;
      6'd18: v = 16'd10805;  6'd19: v = 16'd11040;  6'd20: v = 16'd11285;
      6'd21: v = 16'd11542;  6'd22: v = 16'd11810;  6'd23: v = 16'd12091;
      6'd24: v = 16'd12386;  6'd25: v = 16'd12696;  6'd26: v = 16'd13022;
      6'd27: v = 16'd13364;  6'd28: v = 16'd13725;  6'd29: v = 16'd14107;
      6'd30: v = 16'd14510;  6'd31: v = 16'd14936;  6'd32: v = 16'd15389;
      6'd33: v = 16'd15870;  6'd34: v = 16'd16382;  6'd35: v = 16'd16928;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Normalized reflectivity, Q1.15. Slots beyond the given points read as zero.
  function automatic logic [DATA_W-1:0] bp_refl(input logic [IDX_W-1:0] idx);
    logic [DATA_W-1:0] v;
    case (idx)
      6'd0:  v = 16'd32768;  6'd1:  v = 16'd32768;  6'd2:  v = 16'd32768;
      6'd3:  v = 16'd32767;  6'd4:  v = 16'd32767;  6'd5:  v = 16'd32767;
      6'd6:  v = 16'd32767;  6'd7:  v = 16'd32766;  6'd8:  v = 16'd32766;
      6'd9:  v = 16'd32766;  6'd10: v = 16'd32765;  6'd11: v = 16'd32765;
      6'd12: v = 16'd32765;  6'd13: v = 16'd32764;  6'd14: v = 16'd32764;
      6'd15: v = 16'd32764;  6'd16: v = 16'd32764;  6'd17: v = 16'd32764;
      6'd18: v = 16'd32764;  6'd19: v = 16'd32764;  6'd20: v = 16'd32763;
      6'd21: v = 16'd32763;  6'd22: v = 16'd32763;  6'd23: v = 16'd32762;
      6'd24: v = 16'd32762;  6'd25: v = 16'd32761;  6'd26: v = 16'd32760;
      6'd27: v = 16'd32758;  6'd28: v = 16'd32756;  6'd29: v = 16'd32753;
      6'd30: v = 16'd32750;  6'd31: v = 16'd32746;  6'd32: v = 16'd32742;
      6'd33: v = 16'd32736;  6'd34: v = 16'd32729;  6'd35: v = 16'd32721;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/table_linear_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// table_linear_interpolator: piecewise linear reflectivity lookup with gain
// Interpolates a reflectivity from a 36-point breakpoint ROM, scales it by a
// per-bar gain register and saturates the result at 1.0 (Q1.15).
// ----------------------------------------------------------------------------
// The block handles one item at a time and holds in_ready low while it works.
// An energy below the first breakpoint goes straight from acceptance to the
// gain multiply and rounding. Otherwise the sequencer walks the breakpoint ROM
// one compare per cycle until it finds the segment, then does the multiply,
// loads the divider, runs the serial divider (one quotient bit per cycle for a
// 32-bit dividend), and finishes with the gain multiply and rounding. An
// energy at or above the last breakpoint leaves the search and skips the
// division. The result waits in an output register, so the next item is
// accepted while an earlier result has not been taken yet.
// ----------------------------------------------------------------------------
module table_linear_interpolator import tli_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Input items
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire tli_in_t              in_data,
  // Result items
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output tli_out_t                  out_data,
  // Configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_data
);

  // Gain registers. Writes are always taken.
  logic [DATA_W-1:0] gain_one_r, gain_two_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_one_r <= ONE_Q15;
      gain_two_r <= ONE_Q15;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GAIN_BAR_ONE: gain_one_r <= cfg_data;
        REG_GAIN_BAR_TWO: gain_two_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state and working registers.
  tli_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r;
  logic [DATA_W-1:0] energy_r;
  logic [DATA_W-1:0] gain_r;
  logic [DATA_W-1:0] dist_r;     // energy minus lower breakpoint
  logic [DATA_W-1:0] width_r;    // segment width
  logic [DATA_W-1:0] delta_r;    // magnitude of the reflectivity step
  logic [DATA_W-1:0] base_r;     // reflectivity at the lower breakpoint
  logic              rising_r;
  logic [DATA_W-1:0] refl_r;
  logic              flag_r;
  logic [DIVIDEND_W-1:0] prod_r;

  logic     out_valid_r;
  tli_out_t out_data_r;

  // Breakpoint reads for the search step.
  logic [DATA_W-1:0] bp_hi_e, bp_lo_e, bp_hi_r, bp_lo_r;
  logic [IDX_W-1:0]  idx_lo;
  logic              in_accept;
  logic              below_table;
  logic              seg_hit;
  logic              seg_flat;

  assign idx_lo      = idx_r - 1'b1;
  assign bp_hi_e     = bp_energy(idx_r);
  assign bp_lo_e     = bp_energy(idx_lo);
  assign bp_hi_r     = bp_refl(idx_r);
  assign bp_lo_r     = bp_refl(idx_lo);
  assign in_accept   = in_valid && in_ready;
  assign below_table = (in_data.photon_energy < bp_energy('0));
  assign seg_hit     = (energy_r < bp_hi_e);
  assign seg_flat    = (bp_hi_e <= bp_lo_e);

  // Divider for the interpolation step.
  logic                  div_start;
  logic                  div_done;
  logic [DATA_W-1:0]     div_quo;
  logic [DIVIDEND_W-1:0] div_dividend;

  // Round the step to nearest by adding half the segment width.
  assign div_dividend = prod_r + DIVIDEND_W'(width_r >> 1);

  tli_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (width_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Shared multiplier: distance times step first, then reflectivity times gain.
  logic                  mul_scale;
  logic [DATA_W-1:0]     mul_a, mul_b;
  logic [DIVIDEND_W-1:0] mul_p;

  assign mul_a = mul_scale ? refl_r : dist_r;
  assign mul_b = mul_scale ? gain_r : delta_r;
  assign mul_p = mul_a * mul_b;

  // Rounding and saturation of the scaled product.
  logic [DIVIDEND_W:0]   round_sum;
  logic [DATA_W+1:0]     scaled;
  logic [DATA_W-1:0]     scaled_sat;
  logic                  out_free;

  assign round_sum  = {1'b0, prod_r} + (DIVIDEND_W+1)'(ONE_Q15 >> 1);
  assign scaled     = round_sum[DIVIDEND_W:DATA_W-1];
  assign scaled_sat = (scaled > (DATA_W+2)'(ONE_Q15)) ? ONE_Q15 : scaled[DATA_W-1:0];
  assign out_free   = !out_valid_r || out_ready;

  // Reflectivity after the division, clamped at zero on a falling segment.
  logic [DATA_W-1:0] refl_interp;

  always_comb begin
    if (rising_r) begin
      refl_interp = base_r + div_quo;
    end else if (div_quo >= base_r) begin
      refl_interp = '0;
    end else begin
      refl_interp = base_r - div_quo;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = below_table ? ST_SCALE : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (seg_hit) begin
          state_nxt = seg_flat ? ST_SCALE : ST_MUL;
        end else if (idx_r == LAST_IDX) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_MUL:       state_nxt = ST_DIV_START;
      ST_DIV_START: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE:     state_nxt = ST_ROUND;
      ST_ROUND: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    mul_scale = 1'b0;
    case (state_r)
      ST_IDLE:      in_ready  = 1'b1;
      ST_DIV_START: div_start = 1'b1;
      ST_SCALE:     mul_scale = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_ROUND && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          energy_r <= in_data.photon_energy;
          gain_r   <= in_data.bar_select ? gain_two_r : gain_one_r;
          idx_r    <= IDX_W'(1);
          refl_r   <= bp_refl('0);
          flag_r   <= below_table;
        end
      end
      ST_SEARCH: begin
        if (seg_hit) begin
          dist_r   <= energy_r - bp_lo_e;
          width_r  <= bp_hi_e - bp_lo_e;
          base_r   <= bp_lo_r;
          rising_r <= (bp_hi_r >= bp_lo_r);
          delta_r  <= (bp_hi_r >= bp_lo_r) ? bp_hi_r - bp_lo_r : bp_lo_r - bp_hi_r;
          refl_r   <= bp_lo_r;
        end else if (idx_r == LAST_IDX) begin
          refl_r <= bp_hi_r;
          flag_r <= 1'b1;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
      ST_MUL:   prod_r <= mul_p;
      ST_DIV: begin
        if (div_done) begin
          refl_r <= refl_interp;
        end
      end
      ST_SCALE: prod_r <= mul_p;
      ST_ROUND: begin
        if (out_free) begin
          out_data_r.reflect_probability <= scaled_sat;
          out_data_r.out_of_range        <= flag_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The saturation stage never lets a result above 1.0 through.
  a_result_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.reflect_probability <= ONE_Q15))
    else $error("result exceeds 1.0");

  // The divider only reports completion while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  // The search index stays within the populated part of the table.
  a_search_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> ((idx_r != '0) && (idx_r <= LAST_IDX)))
    else $error("search index out of range");

  // An accepted item always takes the block out of idle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r != ST_IDLE))
    else $error("item accepted but sequencer stayed idle");

endmodule
`default_nettype wire

FILE: hw/rtl/tli_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tli_div: serial restoring divider
// Divides a 32-bit dividend by a nonzero 16-bit divisor, one quotient bit per
// cycle. Only the low 16 quotient bits are returned.
// ----------------------------------------------------------------------------
module tli_div import tli_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DATA_W-1:0]     divisor,
  output logic                       done,
  output logic [DATA_W-1:0]          quotient
);

  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0]     rem_r, rem_nxt;
  logic [DATA_W-1:0]     dvs_r;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                  done_r, done_nxt;
  logic [DATA_W:0]       trial;
  logic                  fits;

  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = DIV_CNT_W'(DIVIDEND_W);
    end else if (cnt_r != '0) begin
      rem_nxt  = fits ? DATA_W'(trial - {1'b0, dvs_r}) : trial[DATA_W-1:0];
      quo_nxt  = {quo_r[DIVIDEND_W-2:0], fits};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r[DATA_W-1:0];

endmodule
`default_nettype wire
